FILE: rtl/audio_jitter_ring_buffer_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the audio jitter ring buffer
// Shared concurrent checks, reset disables them.
// ----------------------------------------------------------------------------
`ifndef AUDIO_JITTER_RING_BUFFER_CORE_DEFINES_SVH
`define AUDIO_JITTER_RING_BUFFER_CORE_DEFINES_SVH

// expression holds at every edge out of reset
`define AJRB_ASSERT_ALWAYS(label, clk_s, rst_s, expr, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (expr)) else $error(msg);

// same-cycle implication
`define AJRB_ASSERT_IMPLY(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define AJRB_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/ajrb_pkg.sv
// ----------------------------------------------------------------------------
// ajrb_pkg
// Constants, types and tables shared by the ring buffer modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ajrb_pkg;

  localparam int STORE_BYTES     = 16384;
  localparam int ADDR_W          = $clog2(STORE_BYTES);
  localparam int FILL_W          = ADDR_W + 1;
  localparam int MAX_PULL_FRAMES = 64;
  localparam int MAX_FRAME_BYTES = 8;
  localparam int PULL_W          = 7;
  localparam int FB_W            = 4;
  localparam int LANE_W          = 3;
  localparam int NEED_W          = PULL_W + FB_W;
  localparam int FRAMES_W        = 15;
  localparam int CNT_W           = 32;
  localparam int WORD_W          = 64;
  localparam int DIV_STEPS       = FILL_W;
  localparam int DIVC_W          = $clog2(DIV_STEPS);

  localparam int CH_W  = 2;
  localparam int SB_W  = 3;
  localparam int CAP_W = 13;

  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;
  localparam int S_TDATA_W  = 16;
  localparam int M_TDATA_W  = 112;

  localparam logic [1:0] REG_CHANNELS = 2'd0;
  localparam logic [1:0] REG_SAMPLE   = 2'd1;
  localparam logic [1:0] REG_CAPACITY = 2'd2;

  localparam logic [CH_W-1:0]  CHANNELS_RESET = CH_W'(2);
  localparam logic [SB_W-1:0]  SAMPLE_RESET   = SB_W'(2);
  localparam logic [CAP_W-1:0] CAPACITY_RESET = CAP_W'(2400);

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_PULL = 1'b1;

  typedef struct packed {
    logic [FB_W-1:0]   fb;
    logic [FILL_W-1:0] size;
  } ring_cfg_t;

  typedef struct packed {
    logic push_go;
    logic pull_go;
    logic div_step;
    logic rd_issue;
    logic capture;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic is_pull;
    logic pull_nonzero;
    logic div_done;
    logic byte_last;
    logic frame_last;
    logic out_free;
  } status_t;

  // whole frames of fb bytes that fit the store
  function automatic logic [FILL_W-1:0] fit_frames(input logic [FB_W-1:0] fb);
    logic [FILL_W-1:0] r;
    case (fb)
      4'd1:    r = FILL_W'(STORE_BYTES / 1);
      4'd2:    r = FILL_W'(STORE_BYTES / 2);
      4'd3:    r = FILL_W'(STORE_BYTES / 3);
      4'd4:    r = FILL_W'(STORE_BYTES / 4);
      4'd5:    r = FILL_W'(STORE_BYTES / 5);
      4'd6:    r = FILL_W'(STORE_BYTES / 6);
      4'd7:    r = FILL_W'(STORE_BYTES / 7);
      default: r = FILL_W'(STORE_BYTES / MAX_FRAME_BYTES);
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/ajrb_ram.sv
// ----------------------------------------------------------------------------
// ajrb_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ajrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/ajrb_regs.sv
// ----------------------------------------------------------------------------
// ajrb_regs
// APB register file; derives frame size and ring size from the registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ajrb_regs (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [ajrb_pkg::APB_ADDR_W-1:0]    paddr,
  input  wire logic [ajrb_pkg::APB_DATA_W-1:0]    pwdata,
  output logic      [ajrb_pkg::APB_DATA_W-1:0]    prdata,
  output logic                                    flush,
  output ajrb_pkg::ring_cfg_t                     ring_cfg
);

  logic [ajrb_pkg::CH_W-1:0]   channels;
  logic [ajrb_pkg::SB_W-1:0]   sample;
  logic [ajrb_pkg::CAP_W-1:0]  capacity;
  logic                        wr;
  logic [1:0]                  idx;
  logic [ajrb_pkg::CH_W-1:0]   ch;
  logic [ajrb_pkg::SB_W-1:0]   sb;
  logic [ajrb_pkg::FB_W-1:0]   prod;
  logic [ajrb_pkg::FB_W-1:0]   fb;
  logic [ajrb_pkg::FILL_W-1:0] frames;
  logic [ajrb_pkg::FILL_W-1:0] fit;
  logic [ajrb_pkg::FILL_W-1:0] frames_c;

  assign wr  = psel & penable & pwrite;
  assign idx = paddr[3:2];

  always_comb begin
    flush = 1'b0;
    if (wr) begin
      case (idx)
        ajrb_pkg::REG_CHANNELS: flush = 1'b1;
        ajrb_pkg::REG_SAMPLE:   flush = 1'b1;
        ajrb_pkg::REG_CAPACITY: flush = 1'b1;
        default:                flush = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      channels <= ajrb_pkg::CHANNELS_RESET;
      sample   <= ajrb_pkg::SAMPLE_RESET;
      capacity <= ajrb_pkg::CAPACITY_RESET;
    end else if (wr) begin
      case (idx)
        ajrb_pkg::REG_CHANNELS: channels <= pwdata[ajrb_pkg::CH_W-1:0];
        ajrb_pkg::REG_SAMPLE:   sample   <= pwdata[ajrb_pkg::SB_W-1:0];
        ajrb_pkg::REG_CAPACITY: capacity <= pwdata[ajrb_pkg::CAP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      ajrb_pkg::REG_CHANNELS:
        prdata = {{(ajrb_pkg::APB_DATA_W-ajrb_pkg::CH_W){1'b0}}, channels};
      ajrb_pkg::REG_SAMPLE:
        prdata = {{(ajrb_pkg::APB_DATA_W-ajrb_pkg::SB_W){1'b0}}, sample};
      ajrb_pkg::REG_CAPACITY:
        prdata = {{(ajrb_pkg::APB_DATA_W-ajrb_pkg::CAP_W){1'b0}}, capacity};
      default:
        prdata = '0;
    endcase
  end

  // clamp fields, frame size, ring size
  always_comb begin
    ch = (channels == '0) ? ajrb_pkg::CH_W'(1) :
         ((channels > ajrb_pkg::CH_W'(2)) ? ajrb_pkg::CH_W'(2) : channels);
    sb = (sample == '0) ? ajrb_pkg::SB_W'(1) :
         ((sample > ajrb_pkg::SB_W'(4)) ? ajrb_pkg::SB_W'(4) : sample);
    prod = {{(ajrb_pkg::FB_W-ajrb_pkg::CH_W){1'b0}}, ch} *
           {{(ajrb_pkg::FB_W-ajrb_pkg::SB_W){1'b0}}, sb};
    fb = (prod > ajrb_pkg::FB_W'(ajrb_pkg::MAX_FRAME_BYTES)) ?
         ajrb_pkg::FB_W'(ajrb_pkg::MAX_FRAME_BYTES) : prod;
    frames = (capacity == '0) ? ajrb_pkg::FILL_W'(1) :
             {{(ajrb_pkg::FILL_W-ajrb_pkg::CAP_W){1'b0}}, capacity};
    fit = ajrb_pkg::fit_frames(fb);
    frames_c = (frames > fit) ? fit : frames;
  end

  assign ring_cfg.fb   = fb;
  assign ring_cfg.size = ajrb_pkg::FILL_W'(frames_c *
                         {{(ajrb_pkg::FILL_W-ajrb_pkg::FB_W){1'b0}}, fb});

endmodule

`default_nettype wire

FILE: rtl/ajrb_ctrl.sv
// ----------------------------------------------------------------------------
// ajrb_ctrl
// Sequencer: push, pull setup, frame-count divide, byte reads, frame output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ajrb_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire ajrb_pkg::status_t status,
  output ajrb_pkg::cmd_t         cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_BYTE = 3'd2;
  localparam logic [2:0] ST_CAPT = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          if (!status.is_pull) begin
            cmd.push_go = 1'b1;
          end else if (status.pull_nonzero) begin
            cmd.pull_go = 1'b1;
            state_next  = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_done) begin
          state_next = ST_BYTE;
        end
      end
      ST_BYTE: begin
        cmd.rd_issue = 1'b1;
        state_next   = ST_CAPT;
      end
      ST_CAPT: begin
        cmd.capture = 1'b1;
        state_next  = status.byte_last ? ST_OUT : ST_BYTE;
      end
      ST_OUT: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = status.frame_last ? ST_IDLE : ST_BYTE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/ajrb_datapath.sv
// ----------------------------------------------------------------------------
// ajrb_datapath
// Ring pointers, sample store, frame assembly, divider and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "audio_jitter_ring_buffer_core_defines.svh"

module ajrb_datapath (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire ajrb_pkg::ring_cfg_t               ring_cfg,
  input  wire logic                              flush,
  input  wire logic [ajrb_pkg::S_TDATA_W-1:0]    s_tdata,
  input  wire logic [0:0]                        s_tuser,
  input  wire ajrb_pkg::cmd_t                    cmd,
  output ajrb_pkg::status_t                      status,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic      [ajrb_pkg::M_TDATA_W-1:0]    m_tdata,
  output logic                                   m_tlast,
  output logic      [0:0]                        m_tuser
);

  localparam int FW = ajrb_pkg::FILL_W;
  localparam int AW = ajrb_pkg::ADDR_W;
  localparam int NW = ajrb_pkg::NEED_W;
  localparam int PW = ajrb_pkg::PULL_W;
  localparam int BW = ajrb_pkg::FB_W;

  logic [AW-1:0] wp;
  logic [AW-1:0] rp;
  logic [FW-1:0] fill;
  logic [ajrb_pkg::CNT_W-1:0] ucount;

  logic [AW-1:0]               rc;
  logic [NW-1:0]               remaining;
  logic [PW-1:0]               frames_rem;
  logic [ajrb_pkg::LANE_W-1:0] lane;
  logic [ajrb_pkg::WORD_W-1:0] word;
  logic                        real_byte;
  logic                        short_flag;
  logic [BW-1:0]               div_rem;
  logic [FW-1:0]               div_q;
  logic [ajrb_pkg::DIVC_W-1:0] div_cnt;

  logic [ajrb_pkg::WORD_W-1:0]   out_data;
  logic [ajrb_pkg::CNT_W-1:0]    out_total;
  logic [ajrb_pkg::FRAMES_W-1:0] out_frames;

  logic [7:0]    data_byte;
  logic [PW-1:0] pf;
  logic [PW-1:0] n;
  logic [NW-1:0] needed;
  logic          shortfall;
  logic [NW-1:0] avail;
  logic [FW-1:0] fb_x;
  logic [FW-1:0] size;
  logic          full;
  logic [FW-1:0] rp_adv;
  logic [FW-1:0] rp_wrap;
  logic [FW-1:0] fill_drop;
  logic [FW-1:0] wp_inc;
  logic [FW-1:0] wp_wrap;
  logic [FW-1:0] rp_pull;
  logic [FW-1:0] rp_pull_wrap;
  logic [FW-1:0] fill_after;
  logic [FW-1:0] rc_inc;
  logic [FW-1:0] rc_wrap;
  logic [BW-1:0] div_shift;
  logic          div_ge;
  logic [7:0]    rdata;
  logic          out_free;

  assign data_byte = s_tdata[7:0];
  assign pf        = s_tdata[14:8];
  assign n         = (pf > PW'(ajrb_pkg::MAX_PULL_FRAMES)) ?
                     PW'(ajrb_pkg::MAX_PULL_FRAMES) : pf;
  assign needed    = {{BW{1'b0}}, n} * {{PW{1'b0}}, ring_cfg.fb};
  assign shortfall = fill < FW'(needed);
  assign avail     = shortfall ? fill[NW-1:0] : needed;
  assign fb_x      = {{(FW-BW){1'b0}}, ring_cfg.fb};
  assign size      = ring_cfg.size;

  assign full      = fill >= size;
  assign rp_adv    = {1'b0, rp} + fb_x;
  assign rp_wrap   = (rp_adv >= size) ? rp_adv - size : rp_adv;
  assign fill_drop = (fill >= fb_x) ? fill - fb_x : '0;
  assign wp_inc    = {1'b0, wp} + FW'(1);
  assign wp_wrap   = (wp_inc >= size) ? '0 : wp_inc;

  assign rp_pull      = {1'b0, rp} + FW'(needed);
  assign rp_pull_wrap = (rp_pull >= size) ? rp_pull - size : rp_pull;
  assign fill_after   = fill - FW'(needed);

  assign rc_inc  = {1'b0, rc} + FW'(1);
  assign rc_wrap = (rc_inc >= size) ? '0 : rc_inc;

  // restoring divide, one quotient bit per step; remainder stays below fb
  assign div_shift = {div_rem[BW-2:0], div_q[FW-1]};
  assign div_ge    = div_shift >= ring_cfg.fb;

  assign out_free = !m_tvalid | m_tready;

  assign status.is_pull      = (s_tuser[0] == ajrb_pkg::CMD_PULL);
  assign status.pull_nonzero = (pf != '0);
  assign status.div_done     = (div_cnt == ajrb_pkg::DIVC_W'(ajrb_pkg::DIV_STEPS - 1));
  assign status.byte_last    = (BW'(lane) == ring_cfg.fb - BW'(1));
  assign status.frame_last   = (frames_rem == PW'(1));
  assign status.out_free     = out_free;

  ajrb_ram #(
    .WIDTH (8),
    .DEPTH (ajrb_pkg::STORE_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (cmd.push_go),
    .waddr (wp),
    .wdata (data_byte),
    .re    (cmd.rd_issue),
    .raddr (rc),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      wp     <= '0;
      rp     <= '0;
      fill   <= '0;
      ucount <= '0;
    end else if (flush) begin
      wp   <= '0;
      rp   <= '0;
      fill <= '0;
    end else if (cmd.push_go) begin
      if (full) begin
        rp   <= rp_wrap[AW-1:0];
        fill <= fill_drop + FW'(1);
      end else begin
        fill <= fill + FW'(1);
      end
      wp <= wp_wrap[AW-1:0];
    end else if (cmd.pull_go) begin
      if (shortfall) begin
        wp     <= '0;
        rp     <= '0;
        fill   <= '0;
        ucount <= ucount + ajrb_pkg::CNT_W'(1);
      end else begin
        rp   <= rp_pull_wrap[AW-1:0];
        fill <= fill_after;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pull_go) begin
      rc         <= rp;
      remaining  <= avail;
      frames_rem <= n;
      lane       <= '0;
      word       <= '0;
      short_flag <= shortfall;
      div_q      <= shortfall ? '0 : fill_after;
      div_rem    <= '0;
      div_cnt    <= '0;
    end
    if (cmd.div_step) begin
      div_rem <= div_ge ? div_shift - ring_cfg.fb : div_shift;
      div_q   <= {div_q[FW-2:0], div_ge};
      div_cnt <= div_cnt + ajrb_pkg::DIVC_W'(1);
    end
    if (cmd.rd_issue) begin
      real_byte <= (remaining != '0);
      if (remaining != '0) begin
        rc        <= rc_wrap[AW-1:0];
        remaining <= remaining - NW'(1);
      end
    end
    if (cmd.capture) begin
      word[lane*8 +: 8] <= real_byte ? rdata : 8'd0;
      if (!status.byte_last) begin
        lane <= lane + ajrb_pkg::LANE_W'(1);
      end
    end
    if (cmd.emit) begin
      frames_rem <= frames_rem - PW'(1);
      lane       <= '0;
      word       <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data   <= word;
      m_tlast    <= status.frame_last;
      m_tuser[0] <= short_flag;
      out_total  <= ucount;
      out_frames <= div_q[ajrb_pkg::FRAMES_W-1:0];
    end
  end

  assign m_tdata = {1'b0, out_frames, out_total, out_data};

  `AJRB_ASSERT_ALWAYS(a_fill_bound, clk, rst, fill <= size, "fill exceeds ring size")
  `AJRB_ASSERT_ALWAYS(a_ptr_bound, clk, rst, ({1'b0, rp} < size) && ({1'b0, wp} < size),
                      "ring pointer outside ring")
  `AJRB_ASSERT_IMPLY(a_emit_free, clk, rst, cmd.emit, out_free,
                     "frame emitted over an unsent beat")
  `AJRB_ASSERT_NEXT(a_short_flush, clk, rst, cmd.pull_go && shortfall,
                    (fill == '0) && (ucount == $past(ucount) + ajrb_pkg::CNT_W'(1)),
                    "short pull did not flush and count")

endmodule

`default_nettype wire

FILE: rtl/audio_jitter_ring_buffer_core.sv
// Push: one beat per cycle, but no beat is taken while a pull is in progress. Pull of n
// frames of fb bytes: setup, a 15-step frame-count divide, then each byte is issued to and
// captured from the store's registered read port, and each frame goes out as one output beat.
// Output stalls delay the pull; the last frame may wait in the output register while pushes go on.
// Reset (synchronous): pointers, fill, underflow count cleared, registers to 2/2/2400;
// the sample store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// audio_jitter_ring_buffer_core
// Byte ring buffer for audio with whole-frame drop on overflow and silence fill.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module audio_jitter_ring_buffer_core (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [ajrb_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire logic [ajrb_pkg::APB_DATA_W-1:0]  pwdata,
  output logic      [ajrb_pkg::APB_DATA_W-1:0]  prdata,
  output logic                                  pready,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  input  wire logic [ajrb_pkg::S_TDATA_W-1:0]   s_tdata,   // data_byte, pull_frames, pad
  input  wire logic [0:0]                       s_tuser,   // command
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  output logic      [ajrb_pkg::M_TDATA_W-1:0]   m_tdata,   // frame_data, underflow_total,
                                                           // buffered_frames, pad
  output logic                                  m_tlast,   // last_frame
  output logic      [0:0]                       m_tuser    // underflow_flag
);

  ajrb_pkg::ring_cfg_t ring_cfg;
  ajrb_pkg::cmd_t      cmd;
  ajrb_pkg::status_t   status;
  logic                flush;

  assign pready = 1'b1;

  ajrb_regs u_regs (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .flush    (flush),
    .ring_cfg (ring_cfg)
  );

  ajrb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  ajrb_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .ring_cfg (ring_cfg),
    .flush    (flush),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .cmd      (cmd),
    .status   (status),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

`default_nettype wire
